// File: design/flcr_pkg.sv
// Shared types and constants for the filled circle row span unit.
// Used by flcr_ctrl, flcr_datapath and filled_circle_row_spans_unit; no dependencies.
`default_nettype none

package flcr_pkg;

	// Largest diameter taken; wider requests saturate here
	localparam logic [5:0]  MAX_DIAMETER = 6'd63;
	// Largest canvas extent; larger register values saturate here
	localparam logic [12:0] CANVAS_MAX   = 13'd4096;
	// Reset value of both canvas size registers
	localparam logic [12:0] CANVAS_RESET = 13'd256;
	// Most significant bit index of the square root (root fits in 5 bits)
	localparam logic [2:0]  ROOT_MSB     = 3'd4;

	// Configuration register indexes
	localparam logic [0:0]  CFG_COLUMNS  = 1'b0;
	localparam logic [0:0]  CFG_ROWS     = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;  // latch an accepted item and restart the row count
		logic prep;       // form the radicand for the current row
		logic root_step;  // resolve one bit of the square root
		logic emit;       // write the current span into the output register
	} flcr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic zero_diam;  // item has diameter zero
		logic root_done;  // final root bit is being resolved
		logic last_row;   // current row is the final one of the item
		logic out_free;   // output register can take a span this cycle
	} flcr_sts_t;

endpackage

`default_nettype wire

// File: design/flcr_ctrl.sv
// Sequencing state machine for the filled circle row span unit.
// Depends on flcr_pkg for the command and status structs.
`default_nettype none

module flcr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire flcr_pkg::flcr_sts_t sts,
	output flcr_pkg::flcr_cmd_t    cmd
);
	import flcr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_EMIT = 4'b1000
	} flcr_state_t;

	flcr_state_t state_q, state_d;

	// Take a new item only between items
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.zero_diam ? ST_EMIT : ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_row ? ST_IDLE : ST_PREP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An accepted item always moves on to radicand preparation
	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_PREP))
		else $error("accepted item did not enter preparation");

	// The root stays in progress until its final bit
	a_root_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && !sts.root_done) |=> (state_q == ST_ROOT))
		else $error("square root left before its final bit");

endmodule

`default_nettype wire

// File: design/flcr_datapath.sv
// Datapath of the filled circle row span unit: item and canvas registers,
// row radicand, bit-serial square root, span clipping and output register.
// Depends on flcr_pkg for constants and the command and status structs.
`default_nettype none

module flcr_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [12:0]          cfg_data,
	input  wire logic signed [12:0]   left_x,
	input  wire logic signed [12:0]   bottom_y,
	input  wire logic [5:0]           diameter,
	input  wire flcr_pkg::flcr_cmd_t  cmd,
	output flcr_pkg::flcr_sts_t       sts,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [13:0]        row_y,
	output logic [11:0]               span_start,
	output logic [11:0]               span_end,
	output logic                      visible,
	output logic                      last
);
	import flcr_pkg::*;

	// Canvas size registers
	logic [12:0] cols_q, rows_q;
	// Item registers
	logic signed [12:0] x_q, y_q;
	logic [5:0]  d_q;
	logic        zero_q;
	logic [10:0] lim_q;
	// Row and root registers
	logic [5:0]  row_q;
	logic [9:0]  rad_q;
	logic [4:0]  root_q;
	logic [2:0]  bit_q;
	// Output register
	logic               out_valid_q;
	logic signed [13:0] row_y_q;
	logic [11:0]        start_q, end_q;
	logic               vis_q, last_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CANVAS_RESET;
			rows_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data;
				CFG_ROWS:    rows_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Saturate the incoming diameter and form the squared radius bound
	logic [5:0]  d_sat;
	logic [5:0]  rp1;
	logic [11:0] lim_full;
	assign d_sat    = (diameter > MAX_DIAMETER) ? MAX_DIAMETER : diameter;
	assign rp1      = {1'b0, d_sat[5:1]} + {5'd0, d_sat[0]};
	assign lim_full = rp1 * rp1;

	// Disc centres: low and high centre column offsets (equal for odd sizes)
	logic [4:0] c_hi, c_lo;
	assign c_hi = d_q[5:1];
	assign c_lo = d_q[5:1] - {4'd0, ~d_q[0]};

	// Vertical distance of the current row to the nearest centre row
	logic        below;
	logic [5:0]  dy_w;
	logic [4:0]  dy;
	logic [9:0]  dy_sq;
	logic [10:0] rad_full;
	assign below    = ({1'b0, c_lo} >= row_q);
	assign dy_w     = below ? ({1'b0, c_lo} - row_q) : (row_q - {1'b0, c_hi});
	assign dy       = dy_w[4:0];
	assign dy_sq    = dy * dy;
	assign rad_full = lim_q - 11'd1 - {1'b0, dy_sq};

	// One bit of the square root per step
	logic [4:0] trial;
	logic [9:0] trial_sq;
	assign trial    = root_q | (5'd1 << bit_q);
	assign trial_sq = trial * trial;

	// Latch the item, advance the row, run the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			bit_q  <= '0;
			zero_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				row_q  <= '0;
				zero_q <= (d_sat == 6'd0);
			end else if (cmd.emit && !sts.last_row) begin
				row_q <= row_q + 6'd1;
			end
			if (cmd.prep) begin
				bit_q <= ROOT_MSB;
			end else if (cmd.root_step) begin
				bit_q <= bit_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q   <= left_x;
			y_q   <= bottom_y;
			d_q   <= d_sat;
			lim_q <= lim_full[10:0];
		end
		if (cmd.prep) begin
			rad_q  <= rad_full[9:0];
			root_q <= '0;
		end else if (cmd.root_step && (trial_sq <= rad_q)) begin
			root_q <= trial;
		end
	end

	// Span ends before clipping
	logic signed [13:0] lo_s, hi_s, y_s;
	assign lo_s = $signed({x_q[12], x_q}) + $signed({9'd0, c_lo}) - $signed({9'd0, root_q});
	assign hi_s = $signed({x_q[12], x_q}) + $signed({9'd0, c_hi}) + $signed({9'd0, root_q});
	assign y_s  = $signed({y_q[12], y_q}) + $signed({8'd0, row_q});

	// Clip against the saturated canvas
	logic [12:0]        cols_eff, rows_eff;
	logic signed [13:0] cols_s, rows_s, cols_m1, lo_c, hi_c;
	logic               vis;
	assign cols_eff = (cols_q > CANVAS_MAX) ? CANVAS_MAX : cols_q;
	assign rows_eff = (rows_q > CANVAS_MAX) ? CANVAS_MAX : rows_q;
	assign cols_s   = $signed({1'b0, cols_eff});
	assign rows_s   = $signed({1'b0, rows_eff});
	assign cols_m1  = cols_s - 14'sd1;
	assign vis      = !zero_q && (y_s >= 14'sd0) && (y_s < rows_s) && (hi_s >= 14'sd0)
	                  && (lo_s < cols_s) && (lo_s <= hi_s);
	assign lo_c     = (lo_s < 14'sd0) ? 14'sd0 : lo_s;
	assign hi_c     = (hi_s > cols_m1) ? cols_m1 : hi_s;

	// Output register: drop a taken item, load a new span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_y_q <= y_s;
			start_q <= vis ? lo_c[11:0] : 12'd0;
			end_q   <= vis ? hi_c[11:0] : 12'd0;
			vis_q   <= vis;
			last_q  <= sts.last_row;
		end
	end

	// Status to the controller
	assign sts.zero_diam = zero_q;
	assign sts.root_done = (bit_q == 3'd0);
	assign sts.last_row  = zero_q || (row_q == (d_q - 6'd1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign row_y      = row_y_q;
	assign span_start = start_q;
	assign span_end   = end_q;
	assign visible    = vis_q;
	assign last       = last_q;

	// A span is never written over one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("span written over a pending item");

	// The row count stays within the circle
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !zero_q) |-> (row_q < d_q))
		else $error("row count ran past the diameter");

	// A visible span is well ordered
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && vis_q) |-> (start_q <= end_q))
		else $error("visible span with start beyond end");

endmodule

`default_nettype wire

// File: design/filled_circle_row_spans_unit.sv
// Top level of the filled circle row span unit: controller plus datapath.
// Depends on flcr_pkg, flcr_ctrl and flcr_datapath.
//
//  channel | handshake                      | payload
//  --------+--------------------------------+------------------------------------------
//  in      | in_valid / in_stall            | left_x, bottom_y, diameter
//  out     | out_valid / out_stall          | row_y, span_start, span_end, visible, last
//  cfg     | cfg_we                         | cfg_index, cfg_data
//
// Each row runs radicand preparation, five root steps of one bit each on a 5x5 trial multiplier, then emit.
// An item of diameter d holds off the input for d rows; diameter zero skips the root and emits one span.
// Reset sets both canvas sizes to 256 and leaves the unit idle with no span pending.
// A stalled output holds the span register and the controller waits in its emit step.
// The last span of an item may wait in the output register while the next item is taken.
`default_nettype none

module filled_circle_row_spans_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [12:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [12:0]  left_x,
	input  wire logic signed [12:0]  bottom_y,
	input  wire logic [5:0]          diameter,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [13:0]       row_y,
	output logic [11:0]              span_start,
	output logic [11:0]              span_end,
	output logic                     visible,
	output logic                     last
);
	import flcr_pkg::*;

	flcr_cmd_t cmd;
	flcr_sts_t sts;

	flcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	flcr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.left_x     (left_x),
		.bottom_y   (bottom_y),
		.diameter   (diameter),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_y      (row_y),
		.span_start (span_start),
		.span_end   (span_end),
		.visible    (visible),
		.last       (last)
	);

endmodule

`default_nettype wire
